// ===== src/lccc_pkg.sv =====
package lccc_pkg;

	// Command codes
	localparam logic [7:0] CMD_POWER  = 8'd1;
	localparam logic [7:0] CMD_ADJUST = 8'd2;
	localparam logic [7:0] CMD_ALARM  = 8'd3;

	// Power sub-codes
	localparam logic [7:0] PWR_OFF    = 8'd1;
	localparam logic [7:0] PWR_WHITE  = 8'd2;
	localparam logic [7:0] PWR_RED    = 8'd3;
	localparam logic [7:0] PWR_GREEN  = 8'd4;
	localparam logic [7:0] PWR_BLUE   = 8'd5;
	localparam logic [7:0] PWR_PURPLE = 8'd6;
	localparam logic [7:0] PWR_YELLOW = 8'd7;

	// Adjust sub-codes
	localparam logic [7:0] ADJ_DIM        = 8'd1;
	localparam logic [7:0] ADJ_BRIGHTEN   = 8'd2;
	localparam logic [7:0] ADJ_RED_DOWN   = 8'd3;
	localparam logic [7:0] ADJ_RED_UP     = 8'd4;
	localparam logic [7:0] ADJ_GREEN_DOWN = 8'd5;
	localparam logic [7:0] ADJ_GREEN_UP   = 8'd6;
	localparam logic [7:0] ADJ_BLUE_DOWN  = 8'd7;
	localparam logic [7:0] ADJ_BLUE_UP    = 8'd8;

	// Alarm sub-code
	localparam logic [7:0] ALM_ON = 8'd1;

	// Lamp modes
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_ON    = 2'd1;
	localparam logic [1:0] MODE_ALARM = 2'd2;

	// Configuration register indexes
	localparam logic [7:0] CFG_PRESET_BRIGHT = 8'd0;
	localparam logic [7:0] CFG_BRIGHT_STEP   = 8'd1;
	localparam logic [7:0] CFG_COLOR_STEP    = 8'd2;

	// Reset values
	localparam logic [6:0] PRESET_BRIGHT_RST = 7'd75;
	localparam logic [6:0] BRIGHT_STEP_RST   = 7'd25;
	localparam logic [7:0] COLOR_STEP_RST    = 8'd64;
	localparam logic [6:0] BRIGHT_RST        = 7'd50;
	localparam logic [7:0] LEVEL_FULL        = 8'hff;
	localparam logic [7:0] LEVEL_WARM        = 8'hf0;
	localparam logic [7:0] LEVEL_ZERO        = 8'h00;

	// Full-scale brightness and reciprocal of 100 (exact for products below 43690)
	localparam logic [7:0]  FULL_SCALE  = 8'd100;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100   = 13'd5243;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] adjust;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  lamp_state;
		logic [6:0]  brightness_level;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [23:0] grb_word;
		logic        beep_request;
	} res_t;

	// Lamp state after one command
	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] bright;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       beep;
	} lccc_snap_t;

endpackage

// ===== src/lccc_state.sv =====
module lccc_state import lccc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       en,
	input  cmd_t       cmd,
	input  logic       cfg_write,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	output lccc_snap_t snap_s1
);

	logic [6:0] preset_bright_q;
	logic [6:0] bright_step_q;
	logic [7:0] color_step_q;
	lccc_snap_t cur_q;
	lccc_snap_t nxt;
	logic [7:0] dim_val;
	logic [7:0] brt_val;
	logic       preset_ok;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_bright_q <= PRESET_BRIGHT_RST;
			bright_step_q   <= BRIGHT_STEP_RST;
			color_step_q    <= COLOR_STEP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PRESET_BRIGHT: preset_bright_q <= cfg_data[6:0];
				CFG_BRIGHT_STEP:   bright_step_q   <= cfg_data[6:0];
				CFG_COLOR_STEP:    color_step_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Candidate brightness values
	assign dim_val   = {1'b0, cur_q.bright} - {1'b0, bright_step_q};
	assign brt_val   = {1'b0, cur_q.bright} + {1'b0, bright_step_q};
	assign preset_ok = ({1'b0, preset_bright_q} <= FULL_SCALE);

	// Decode the command against the current state
	always_comb begin
		nxt      = cur_q;
		nxt.beep = 1'b0;
		unique case (cmd.command)
			CMD_POWER: begin
				unique case (cmd.adjust)
					PWR_OFF:    nxt.mode = MODE_OFF;
					PWR_WHITE:  {nxt.red, nxt.green, nxt.blue} = {LEVEL_FULL, LEVEL_FULL, LEVEL_WARM};
					PWR_RED:    {nxt.red, nxt.green, nxt.blue} = {LEVEL_FULL, LEVEL_ZERO, LEVEL_ZERO};
					PWR_GREEN:  {nxt.red, nxt.green, nxt.blue} = {LEVEL_ZERO, LEVEL_FULL, LEVEL_ZERO};
					PWR_BLUE:   {nxt.red, nxt.green, nxt.blue} = {LEVEL_ZERO, LEVEL_ZERO, LEVEL_FULL};
					PWR_PURPLE: {nxt.red, nxt.green, nxt.blue} = {LEVEL_FULL, LEVEL_ZERO, LEVEL_FULL};
					PWR_YELLOW: {nxt.red, nxt.green, nxt.blue} = {LEVEL_FULL, LEVEL_FULL, LEVEL_ZERO};
					default: ;
				endcase
				// Any preset turns the lamp on and loads the preset brightness if it is within full scale
				if (cmd.adjust >= PWR_WHITE && cmd.adjust <= PWR_YELLOW) begin
					nxt.mode = MODE_ON;
					if (preset_ok) nxt.bright = preset_bright_q;
				end
			end
			CMD_ADJUST: begin
				unique case (cmd.adjust)
					ADJ_DIM:        if (!dim_val[7]) nxt.bright = dim_val[6:0];
					ADJ_BRIGHTEN:   if (brt_val <= FULL_SCALE) nxt.bright = brt_val[6:0];
					ADJ_RED_DOWN:   nxt.red   = cur_q.red   - color_step_q;
					ADJ_RED_UP:     nxt.red   = cur_q.red   + color_step_q;
					ADJ_GREEN_DOWN: nxt.green = cur_q.green - color_step_q;
					ADJ_GREEN_UP:   nxt.green = cur_q.green + color_step_q;
					ADJ_BLUE_DOWN:  nxt.blue  = cur_q.blue  - color_step_q;
					ADJ_BLUE_UP:    nxt.blue  = cur_q.blue  + color_step_q;
					default: ;
				endcase
			end
			CMD_ALARM: begin
				if (cmd.adjust == ALM_ON) begin
					nxt.mode = MODE_ALARM;
					nxt.beep = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Commit state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.mode   <= MODE_OFF;
			cur_q.bright <= BRIGHT_RST;
			cur_q.red    <= LEVEL_FULL;
			cur_q.green  <= LEVEL_FULL;
			cur_q.blue   <= LEVEL_WARM;
			cur_q.beep   <= 1'b0;
		end else if (take) begin
			cur_q <= nxt;
		end
	end

	// Snapshot of the state after this command
	always_ff @(posedge clk) begin
		if (en) snap_s1 <= nxt;
	end

endmodule

// ===== src/lccc_scale.sv =====
module lccc_scale import lccc_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] level,
	input  logic [6:0] bright,
	output logic [7:0] scaled_s3
);

	logic [14:0] prod_s2;
	logic [27:0] recip_prod;

	// Multiply level by brightness
	always_ff @(posedge clk) begin
		if (en) prod_s2 <= level * bright;
	end

	// Divide by full scale through the reciprocal
	assign recip_prod = prod_s2 * RECIP_100;

	always_ff @(posedge clk) begin
		if (en) scaled_s3 <= recip_prod[RECIP_SHIFT +: 8];
	end

endmodule

// ===== src/led_color_command_controller_core.sv =====
// Pipeline: a command's result is registered through snap_s1, prod_s2 and scaled_s3.
// Throughput: one command per cycle; state is updated in the transfer cycle,
// then the level*brightness multiply and the divide-by-100 reciprocal take a stage each.
// The pipeline stalls as a whole only while a result is held at the output.
// Reset: lamp off, brightness 50, color 255/255/240, registers 75/25/64, pipeline empty.
module led_color_command_controller_core import lccc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_write,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic       en;
	logic       take;
	logic       valid_s1;
	logic       valid_s2;
	lccc_snap_t snap_s1;
	lccc_snap_t snap_s2;
	lccc_snap_t snap_s3;
	logic [7:0] red_sc_s3;
	logic [7:0] green_sc_s3;
	logic [7:0] blue_sc_s3;

	// Advance whenever the output slot is free or being drained
	assign en        = !res_valid || res_ready;
	assign cmd_ready = en;
	assign take      = cmd_valid && en;

	lccc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.en        (en),
		.cmd       (cmd),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.snap_s1   (snap_s1)
	);

	lccc_scale u_scale_red (
		.clk       (clk),
		.en        (en),
		.level     (snap_s1.red),
		.bright    (snap_s1.bright),
		.scaled_s3 (red_sc_s3)
	);

	lccc_scale u_scale_green (
		.clk       (clk),
		.en        (en),
		.level     (snap_s1.green),
		.bright    (snap_s1.bright),
		.scaled_s3 (green_sc_s3)
	);

	lccc_scale u_scale_blue (
		.clk       (clk),
		.en        (en),
		.level     (snap_s1.blue),
		.bright    (snap_s1.bright),
		.scaled_s3 (blue_sc_s3)
	);

	// Track valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= take;
			valid_s2  <= valid_s1;
			res_valid <= valid_s2;
		end
	end

	// Carry the unscaled state alongside the multipliers
	always_ff @(posedge clk) begin
		if (en) begin
			snap_s2 <= snap_s1;
			snap_s3 <= snap_s2;
		end
	end

	// Assemble the result
	always_comb begin
		res.lamp_state       = snap_s3.mode;
		res.brightness_level = snap_s3.bright;
		res.red_out          = snap_s3.red;
		res.green_out        = snap_s3.green;
		res.blue_out         = snap_s3.blue;
		res.grb_word         = {green_sc_s3, red_sc_s3, blue_sc_s3};
		res.beep_request     = snap_s3.beep;
	end

	// A beep only comes with the alarm state
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.beep_request |-> res.lamp_state == MODE_ALARM)
		else $error("beep without alarm state");

	// Brightness never leaves full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {1'b0, res.brightness_level} <= FULL_SCALE)
		else $error("brightness above full scale");

	// Scaling never raises a channel
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.grb_word[15:8] <= res.red_out
			&& res.grb_word[23:16] <= res.green_out && res.grb_word[7:0] <= res.blue_out)
		else $error("scaled channel above level");

	// A waiting result holds the input off and stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !cmd_ready ##1 (res_valid && $stable(res)))
		else $error("pipeline advanced under stall");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lccc_pkg::*;

	localparam int LONG_HOLD    = 150;
	localparam int SETTLE_TICKS = 6;
	localparam int STALL_LIMIT  = 4000;

	// Indexes past the last register; writes there must be ignored
	localparam logic [7:0] CFG_BEYOND = CFG_COLOR_STEP + 8'd1;
	localparam logic [7:0] CFG_TOP    = 8'hff;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	cmd_t       cmd = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_write = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	led_color_command_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Lamp state and register copy for prediction
	logic [6:0] preset_level = PRESET_BRIGHT_RST;
	logic [6:0] dim_step     = BRIGHT_STEP_RST;
	logic [7:0] hue_step     = COLOR_STEP_RST;
	logic [1:0] lamp_mode    = MODE_OFF;
	logic [6:0] lamp_bright  = BRIGHT_RST;
	logic [7:0] lamp_red     = LEVEL_FULL;
	logic [7:0] lamp_green   = LEVEL_FULL;
	logic [7:0] lamp_blue    = LEVEL_WARM;

	cmd_t command_queue[$];
	res_t expected_results[$];
	int   items_queued = 0;
	int   items_accepted = 0;
	int   results_seen = 0;
	int   failures = 0;
	bit   send_idle = 1'b1;
	bit   recv_idle = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	// Brightness moves only when the new value stays within 0..100
	function automatic void set_bright(int value);
		if (value >= 0 && value <= int'(FULL_SCALE)) begin
			lamp_bright = value[6:0];
		end
	endfunction

	function automatic void load_preset(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		lamp_mode  = MODE_ON;
		lamp_red   = r;
		lamp_green = g;
		lamp_blue  = b;
		set_bright(int'(preset_level));
	endfunction

	function automatic logic [7:0] dimmed(logic [7:0] level);
		int product;
		product = int'(level) * int'(lamp_bright) / int'(FULL_SCALE);
		return product[7:0];
	endfunction

	// Advance the lamp by one command and return the result it should produce
	function automatic res_t apply_command(cmd_t c);
		res_t r;
		logic beep;
		beep = 1'b0;
		case (c.command)
			CMD_POWER: begin
				case (c.adjust)
					PWR_OFF:    lamp_mode = MODE_OFF;
					PWR_WHITE:  load_preset(LEVEL_FULL, LEVEL_FULL, LEVEL_WARM);
					PWR_RED:    load_preset(LEVEL_FULL, LEVEL_ZERO, LEVEL_ZERO);
					PWR_GREEN:  load_preset(LEVEL_ZERO, LEVEL_FULL, LEVEL_ZERO);
					PWR_BLUE:   load_preset(LEVEL_ZERO, LEVEL_ZERO, LEVEL_FULL);
					PWR_PURPLE: load_preset(LEVEL_FULL, LEVEL_ZERO, LEVEL_FULL);
					PWR_YELLOW: load_preset(LEVEL_FULL, LEVEL_FULL, LEVEL_ZERO);
					default: ;
				endcase
			end
			CMD_ADJUST: begin
				case (c.adjust)
					ADJ_DIM:        set_bright(int'(lamp_bright) - int'(dim_step));
					ADJ_BRIGHTEN:   set_bright(int'(lamp_bright) + int'(dim_step));
					ADJ_RED_DOWN:   lamp_red = lamp_red - hue_step;
					ADJ_RED_UP:     lamp_red = lamp_red + hue_step;
					ADJ_GREEN_DOWN: lamp_green = lamp_green - hue_step;
					ADJ_GREEN_UP:   lamp_green = lamp_green + hue_step;
					ADJ_BLUE_DOWN:  lamp_blue = lamp_blue - hue_step;
					ADJ_BLUE_UP:    lamp_blue = lamp_blue + hue_step;
					default: ;
				endcase
			end
			CMD_ALARM: begin
				if (c.adjust == ALM_ON) begin
					lamp_mode = MODE_ALARM;
					beep = 1'b1;
				end
			end
			default: ;
		endcase
		r.lamp_state       = lamp_mode;
		r.brightness_level = lamp_bright;
		r.red_out          = lamp_red;
		r.green_out        = lamp_green;
		r.blue_out         = lamp_blue;
		r.grb_word         = {dimmed(lamp_green), dimmed(lamp_red), dimmed(lamp_blue)};
		r.beep_request     = beep;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Well-formed commands with random content, plus some noise
	function automatic cmd_t random_command();
		cmd_t c;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 38) begin
			c.command = CMD_ADJUST;
			c.adjust  = 8'($urandom_range(ADJ_DIM, ADJ_BLUE_UP));
		end else if (roll < 68) begin
			c.command = CMD_POWER;
			c.adjust  = 8'($urandom_range(PWR_OFF, PWR_YELLOW));
		end else if (roll < 74) begin
			c.command = CMD_ALARM;
			c.adjust  = ALM_ON;
		end else if (roll < 86) begin
			c.command = 8'($urandom_range(CMD_POWER, CMD_ALARM));
			c.adjust  = 8'($urandom_range(0, 255));
		end else begin
			c.command = 8'($urandom_range(0, 255));
			c.adjust  = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	task automatic queue_command(logic [7:0] command, logic [7:0] adjust);
		cmd_t c;
		c.command = command;
		c.adjust  = adjust;
		command_queue.push_back(c);
		items_queued++;
	endtask

	task automatic queue_random(int count);
		repeat (count) begin
			command_queue.push_back(random_command());
			items_queued++;
		end
	endtask

	// Write one register and mirror it; only called while the block is idle
	task automatic write_reg(logic [7:0] index, logic [7:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		case (index)
			CFG_PRESET_BRIGHT: preset_level = data[6:0];
			CFG_BRIGHT_STEP:   dim_step = data[6:0];
			CFG_COLOR_STEP:    hue_step = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic configure(logic [7:0] preset, logic [7:0] bstep, logic [7:0] cstep);
		write_reg(CFG_PRESET_BRIGHT, preset);
		write_reg(CFG_BRIGHT_STEP, bstep);
		write_reg(CFG_COLOR_STEP, cstep);
	endtask

	// Hold the sender until every expected result is back, then let the pipe settle
	task automatic wait_idle();
		while (items_accepted != items_queued || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic compare_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			$error("result transfer with no command outstanding");
			failures++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("lamp_state", want.lamp_state, got.lamp_state);
		compare_field("brightness_level", want.brightness_level, got.brightness_level);
		compare_field("red_out", want.red_out, got.red_out);
		compare_field("green_out", want.green_out, got.green_out);
		compare_field("blue_out", want.blue_out, got.blue_out);
		compare_field("grb_word", want.grb_word, got.grb_word);
		compare_field("beep_request", want.beep_request, got.beep_request);
	endtask

	// Command driver: offer queued commands with random gaps between transfers
	int   send_gap = 0;
	bit   offering = 1'b0;
	cmd_t next_cmd = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap = 0;
			offering = 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				expected_results.push_back(apply_command(cmd));
				items_accepted++;
				offering = 1'b0;
				send_gap = send_idle ? pick_gap() : 0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (command_queue.size() > 0) begin
					next_cmd = command_queue.pop_front();
					offering = 1'b1;
				end
			end
			cmd_valid <= offering;
			cmd <= next_cmd;
		end
	end

	// Result monitor: check each transfer, stall at random, hold off long twice
	int recv_gap = 0;
	int hold_left = 0;
	int next_hold_at = 300;
	bit ready_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				check_result(res);
				results_seen++;
			end
			if (results_seen >= next_hold_at) begin
				hold_left = LONG_HOLD;
				next_hold_at += 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
				if (recv_idle && $urandom_range(0, 2) == 0) begin
					recv_gap = pick_gap();
				end
			end
			res_ready <= ready_next;
		end
	end

	// Drop the run if nothing moves for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: walk every operation and the range edges
		queue_command(CMD_ADJUST, ADJ_DIM);
		queue_command(CMD_ADJUST, ADJ_DIM);
		queue_command(CMD_ADJUST, ADJ_DIM);         // would go below zero
		queue_command(CMD_POWER, PWR_WHITE);
		queue_command(CMD_ADJUST, ADJ_BRIGHTEN);
		queue_command(CMD_ADJUST, ADJ_BRIGHTEN);    // would pass full scale
		queue_command(CMD_ADJUST, ADJ_RED_UP);      // wraps past 255
		queue_command(CMD_ADJUST, ADJ_RED_DOWN);
		queue_command(CMD_ADJUST, ADJ_GREEN_DOWN);
		queue_command(CMD_ADJUST, ADJ_GREEN_UP);
		queue_command(CMD_ADJUST, ADJ_BLUE_DOWN);
		queue_command(CMD_ADJUST, ADJ_BLUE_UP);
		queue_command(CMD_POWER, PWR_RED);
		queue_command(CMD_POWER, PWR_GREEN);
		queue_command(CMD_POWER, PWR_BLUE);
		queue_command(CMD_ADJUST, ADJ_RED_DOWN);    // wraps below zero
		queue_command(CMD_POWER, PWR_PURPLE);
		queue_command(CMD_POWER, PWR_YELLOW);
		queue_command(CMD_ALARM, ALM_ON);
		queue_command(CMD_ALARM, ALM_ON);           // alarm again still beeps
		queue_command(CMD_POWER, PWR_OFF);
		queue_command(CMD_ADJUST, ADJ_BLUE_UP);     // color still scaled while off
		queue_command(8'h00, 8'h00);
		queue_command(8'hff, 8'hff);
		queue_command(CMD_POWER, PWR_YELLOW + 8'd1);
		queue_command(CMD_ADJUST, ADJ_BLUE_UP + 8'd1);
		queue_command(CMD_ALARM, ALM_ON + 8'd1);
		wait_idle();

		// Top of every register field: preset above full scale, huge steps
		configure(8'hff, 8'hff, 8'hff);
		queue_command(CMD_POWER, PWR_WHITE);
		queue_command(CMD_ADJUST, ADJ_BRIGHTEN);
		queue_command(CMD_ADJUST, ADJ_DIM);
		queue_command(CMD_ADJUST, ADJ_GREEN_UP);
		queue_command(CMD_POWER, PWR_BLUE);
		queue_random(80);
		wait_idle();

		// All zero, no idling on either side; stray indexes must not land
		send_idle = 1'b0;
		recv_idle = 1'b0;
		configure(8'h00, 8'h00, 8'h00);
		write_reg(CFG_BEYOND, 8'h3c);
		write_reg(CFG_TOP, 8'h55);
		queue_random(100);
		wait_idle();

		// Full-scale preset and brightness step, unit color step
		send_idle = 1'b1;
		recv_idle = 1'b1;
		configure(8'd100, 8'd100, 8'd1);
		queue_command(CMD_POWER, PWR_GREEN);
		queue_command(CMD_ADJUST, ADJ_DIM);
		queue_command(CMD_ADJUST, ADJ_BRIGHTEN);
		queue_random(100);
		wait_idle();

		// Random settings, mostly in range
		repeat (8) begin
			configure(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 100)),
				8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 40)),
				8'($urandom_range(0, 255)));
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			queue_random(110);
			wait_idle();
		end

		if (failures == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
